### rtl/cip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cip_pkg
// Shared types and constants for the CFF INDEX stream parser.
// ----------------------------------------------------------------------------
package cip_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned CountW  = 16;
	localparam int unsigned WordW   = 32;
	localparam int unsigned OffNumW = CountW + 1;
	localparam int unsigned OffSzW  = 3;
	localparam logic [ByteW-1:0] OffSzMax = ByteW'(4);

	// Parser phase
	typedef enum logic [2:0] {
		PH_COUNT_HI = 3'd0,
		PH_COUNT_LO = 3'd1,
		PH_OFFSIZE  = 3'd2,
		PH_OFFSET   = 3'd3,
		PH_DATA     = 3'd4
	} phase_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_OFFSET = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [WordW-1:0]   value;
		logic [WordW-1:0]   position;
		logic               last;
	} result_t;

endpackage : cip_pkg
`default_nettype wire

### rtl/cip_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cip_if
// Valid/ready channels: byte requests in, parse results out.
// ----------------------------------------------------------------------------
interface cip_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       restart;

	modport source (output valid, output in_byte, output restart, input ready);
	modport sink   (input valid, input in_byte, input restart, output ready);
endinterface : cip_in_if

interface cip_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] value;
	logic [31:0] position;
	logic        last;

	modport source (output valid, output kind, output value, output position,
		output last, input ready);
	modport sink   (input valid, input kind, input value, input position,
		input last, output ready);
endinterface : cip_out_if
`default_nettype wire

### rtl/cff_index_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cff_index_parser
// Streams a CFF INDEX byte by byte: header, offsets, then data bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                         Notes
//  bytes     in   in_byte[7:0], restart           one INDEX byte per request
//  results   out  kind[1:0], value[31:0],         zero or one result per byte
//                 position[31:0], last
//
// Throughput is one byte per cycle while the result register is not stalled;
// the parse step is a single 32-bit shift, add and compare between the input
// register and the result register, which holds each result that is produced.
// arst_n clears valid flags and parser state to "awaiting count high byte".
// A stalled result holds the result register; the input register still
// drains bytes that produce no result, and the input stalls only when a
// result-producing byte finds the result register full and not draining.
//
module cff_index_parser import cip_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cip_in_if.sink     bytes,
	cip_out_if.source  results
);

	// Input register
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             restart_s1;

	logic    has_result;
	result_t result;
	logic    out_free;
	logic    advance;

	// The registered byte moves into the parser state when its result (if
	// any) has a place in the result register.
	assign advance     = valid_s1 && (out_free || !has_result);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1    <= bytes.in_byte;
			restart_s1 <= bytes.restart;
		end
	end

	// Parser state and per-byte decode
	cip_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.in_byte    (byte_s1),
		.restart    (restart_s1),
		.has_result (has_result),
		.result     (result)
	);

	// Result register
	cip_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && has_result),
		.result  (result),
		.free    (out_free),
		.out_res (results)
	);

endmodule : cff_index_parser
`default_nettype wire

### rtl/cip_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cip_decode
// Parser state and the per-byte next-state / result logic.
// ----------------------------------------------------------------------------
module cip_decode import cip_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [ByteW-1:0] in_byte,
	input  wire logic             restart,
	output      logic             has_result,
	output      result_t          result
);

	phase_t              phase_q, phase_d;
	logic [CountW-1:0]   count_q, count_d;
	logic [OffSzW-1:0]   width_q, width_d;
	logic [OffSzW-1:0]   left_q, left_d;
	logic [WordW-1:0]    acc_q, acc_d;
	logic [OffNumW-1:0]  num_q, num_d;
	logic [WordW-1:0]    len_q, len_d;
	logic [WordW-1:0]    cnt_q, cnt_d;

	phase_t              ph_eff;
	logic [WordW-1:0]    acc_shift;
	logic [OffSzW-1:0]   left_dec;
	logic [WordW-1:0]    cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT_HI;
			count_q <= '0;
			width_q <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			num_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
			width_q <= width_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			num_q   <= num_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		ph_eff     = restart ? PH_COUNT_HI : phase_q;
		acc_shift  = {acc_q[WordW-ByteW-1:0], in_byte};
		left_dec   = left_q - OffSzW'(1);
		cnt_inc    = cnt_q + WordW'(1);

		phase_d    = ph_eff;
		count_d    = count_q;
		width_d    = width_q;
		left_d     = left_q;
		acc_d      = acc_q;
		num_d      = num_q;
		len_d      = len_q;
		cnt_d      = cnt_q;

		has_result      = 1'b0;
		result.kind     = KIND_OFFSET;
		result.value    = '0;
		result.position = '0;
		result.last     = 1'b0;

		case (ph_eff)
			PH_COUNT_LO: begin
				count_d = {count_q[CountW-1:ByteW], in_byte};
				phase_d = PH_OFFSIZE;
			end
			PH_OFFSIZE: begin
				width_d = in_byte[OffSzW-1:0];
				if (count_q == '0) begin
					phase_d     = PH_COUNT_HI;
					has_result  = 1'b1;
					result.kind = KIND_EMPTY;
					result.last = 1'b1;
				end else if (in_byte == '0 || in_byte > OffSzMax) begin
					phase_d     = PH_COUNT_HI;
					has_result  = 1'b1;
					result.kind = KIND_ERROR;
					result.last = 1'b1;
				end else begin
					left_d  = in_byte[OffSzW-1:0];
					acc_d   = '0;
					num_d   = '0;
					len_d   = '0;
					cnt_d   = '0;
					phase_d = PH_OFFSET;
				end
			end
			PH_OFFSET: begin
				acc_d  = acc_shift;
				left_d = left_dec;
				if (left_dec == '0) begin
					has_result = 1'b1;
					if (num_q >= {1'b0, count_q}) begin
						// final offset sets the data length
						if (acc_shift == '0) begin
							phase_d     = PH_COUNT_HI;
							result.kind = KIND_ERROR;
							result.last = 1'b1;
						end else begin
							len_d           = acc_shift - WordW'(1);
							cnt_d           = '0;
							result.kind     = KIND_OFFSET;
							result.value    = acc_shift;
							result.position = WordW'(num_q);
							if (acc_shift == WordW'(1)) begin
								phase_d     = PH_COUNT_HI;
								result.last = 1'b1;
							end else begin
								phase_d = PH_DATA;
							end
						end
					end else begin
						num_d           = num_q + OffNumW'(1);
						left_d          = width_q;
						acc_d           = '0;
						result.kind     = KIND_OFFSET;
						result.value    = acc_shift;
						result.position = WordW'(num_q);
					end
				end
			end
			PH_DATA: begin
				cnt_d           = cnt_inc;
				has_result      = 1'b1;
				result.kind     = KIND_DATA;
				result.value    = WordW'(in_byte);
				result.position = cnt_q;
				if (cnt_inc == len_q) begin
					result.last = 1'b1;
					phase_d     = PH_COUNT_HI;
				end
			end
			default: begin
				count_d = {in_byte, ByteW'(0)};
				phase_d = PH_COUNT_LO;
			end
		endcase
	end

endmodule : cip_decode
`default_nettype wire

### rtl/cip_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cip_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module cip_out_reg import cip_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t result,
	output      logic    free,
	cip_out_if.source    out_res
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || out_res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign out_res.valid    = valid_q;
	assign out_res.kind     = res_q.kind;
	assign out_res.value    = res_q.value;
	assign out_res.position = res_q.position;
	assign out_res.last     = res_q.last;

endmodule : cip_out_reg
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cff_index_parser. A directed table walks the
// header cases, error paths, restart and the widest offset, then random
// INDEX streams (mostly well formed, some truncated, some header errors,
// some raw noise) run under four source/sink throttling profiles. Every
// accepted byte request is fed to an in-bench parser model, and each
// result the block hands out is matched against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import cip_pkg::*;

	localparam int CLK_HALF  = 6;
	localparam int RST_CYC   = 5;
	localparam int TIMEOUT   = 400000;
	localparam int DRAIN_CYC = 16;
	localparam int DIR_N     = 30;
	localparam int PHASE_LEN = 225;

	localparam result_t NO_RES    = '0;
	localparam result_t ERR_RES   = '{KIND_ERROR, 32'd0, 32'd0, 1'b1};
	localparam result_t EMPTY_RES = '{KIND_EMPTY, 32'd0, 32'd0, 1'b1};
	localparam result_t WIDE_OFF  = '{KIND_OFFSET, 32'hFFFF_FFFF, 32'd0, 1'b0};

	// one row of the directed table; pin = expected result typed in by hand
	typedef struct packed {
		logic [7:0] val;
		logic       rst;
		logic       pin;
		result_t    want;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cip_in_if  byte_ch ();
	cip_out_if result_ch ();

	cff_index_parser u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (result_ch)
	);

	always #CLK_HALF clk = ~clk;

	// throttling
	int idle_pct  = 0;
	int stall_pct = 0;
	int idle_tab  [4] = '{0, 48, 0, 24};
	int stall_tab [4] = '{0, 0, 48, 24};

	// bookkeeping
	result_t pending_results [$];
	int      cycle_cnt = 0;
	int      n_fail    = 0;
	int      n_sent    = 0;
	int      n_offs    = 0;
	int      n_data    = 0;
	int      n_empty   = 0;
	int      n_err     = 0;

	// pinned expectation of the request currently on the bus
	logic    row_pin  = 1'b0;
	result_t row_want = '0;

	// random stream under construction: {restart, byte}
	logic [8:0] seq_q [$];
	bit         dirty = 1'b0;

	stim_row_t dir_tab [DIR_N];

	// ------------------------------------------------------------------
	// parser model state
	// ------------------------------------------------------------------
	phase_t      ph       = PH_COUNT_HI;
	logic [15:0] ent_cnt  = '0;
	logic [2:0]  off_w    = '0;
	logic [2:0]  off_left = '0;
	logic [31:0] off_acc  = '0;
	logic [16:0] off_num  = '0;
	logic [31:0] dat_len  = '0;
	logic [31:0] dat_pos  = '0;

	// advance the model by one byte; returns 1 when a result comes out
	function automatic bit parse_byte(input logic [7:0] b, input logic rst,
			output result_t res);
		logic [16:0] idx;
		logic [31:0] p;
		bit          fin;
		res = NO_RES;
		if (rst)
			ph = PH_COUNT_HI;
		case (ph)
			PH_COUNT_LO: begin
				ent_cnt[7:0] = b;
				ph = PH_OFFSIZE;
				return 1'b0;
			end
			PH_OFFSIZE: begin
				off_w = b[2:0];
				if (ent_cnt == 16'd0) begin
					ph  = PH_COUNT_HI;
					res = EMPTY_RES;
					return 1'b1;
				end
				if (b < 8'd1 || b > OffSzMax) begin
					ph  = PH_COUNT_HI;
					res = ERR_RES;
					return 1'b1;
				end
				off_left = b[2:0];
				off_acc  = '0;
				off_num  = '0;
				dat_len  = '0;
				dat_pos  = '0;
				ph = PH_OFFSET;
				return 1'b0;
			end
			PH_OFFSET: begin
				off_acc  = {off_acc[23:0], b};
				off_left = off_left - 3'd1;
				if (off_left != 3'd0)
					return 1'b0;
				if (off_num >= {1'b0, ent_cnt}) begin
					// final offset: sets the data length
					if (off_acc == 32'd0) begin
						ph  = PH_COUNT_HI;
						res = ERR_RES;
						return 1'b1;
					end
					dat_len = off_acc - 32'd1;
					dat_pos = '0;
					res = '{KIND_OFFSET, off_acc, 32'(off_num), 1'b0};
					if (dat_len == 32'd0) begin
						ph = PH_COUNT_HI;
						res.last = 1'b1;
					end else begin
						ph = PH_DATA;
					end
					return 1'b1;
				end
				idx      = off_num;
				res      = '{KIND_OFFSET, off_acc, 32'(idx), 1'b0};
				off_num  = off_num + 17'd1;
				off_left = off_w;
				off_acc  = '0;
				return 1'b1;
			end
			PH_DATA: begin
				p   = dat_pos;
				fin = ((p + 32'd1) == dat_len);
				dat_pos = p + 32'd1;
				if (fin)
					ph = PH_COUNT_HI;
				res = '{KIND_DATA, {24'd0, b}, p, fin};
				return 1'b1;
			end
			default: begin
				ent_cnt = {b, 8'h00};
				ph = PH_COUNT_LO;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		n_fail++;
		$display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
	endtask

	// ------------------------------------------------------------------
	// monitor: check results first, then predict from the accepted request
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t w;
		result_t pr;
		bit      has;
		if (arst_n) begin
			cycle_cnt++;
			if (cycle_cnt >= TIMEOUT) begin
				$display("tb: timeout after %0d cycles", cycle_cnt);
				$display("tb: failure");
				$finish;
			end
			if (result_ch.valid && result_ch.ready) begin
				case (result_ch.kind)
					KIND_OFFSET: n_offs++;
					KIND_DATA:   n_data++;
					KIND_EMPTY:  n_empty++;
					default:     n_err++;
				endcase
				if (pending_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result k%0d v%h p%0d l%0b",
						result_ch.kind, result_ch.value, result_ch.position,
						result_ch.last));
				end else begin
					w = pending_results.pop_front();
					if (result_ch.kind !== w.kind || result_ch.value !== w.value ||
							result_ch.position !== w.position ||
							result_ch.last !== w.last)
						flag_mismatch($sformatf(
							"got k%0d v%h p%0d l%0b, want k%0d v%h p%0d l%0b",
							result_ch.kind, result_ch.value, result_ch.position,
							result_ch.last, w.kind, w.value, w.position, w.last));
				end
			end
			if (byte_ch.valid && byte_ch.ready) begin
				has = parse_byte(byte_ch.in_byte, byte_ch.restart, pr);
				if (row_pin)
					pending_results.push_back(row_want);
				else if (has)
					pending_results.push_back(pr);
			end
		end
	end

	// sink side back-pressure
	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= stall_pct);

	// ------------------------------------------------------------------
	// source side: one byte request, entered and left at a falling edge
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic rst,
			input logic pin, input result_t want);
		while ($urandom_range(99) < idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		byte_ch.restart <= rst;
		row_pin  = pin;
		row_want = want;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
		row_pin = 1'b0;
	endtask

	task automatic push_b(input logic [7:0] b);
		seq_q.push_back({1'b0, b});
	endtask

	// INDEX with random content into seq_q, well formed but for an occasional zero final offset
	task automatic build_index();
		int          r;
		int          osz;
		int          dlen;
		logic [15:0] cnt;
		logic [31:0] val;
		logic [31:0] fin_off;
		r   = $urandom_range(99);
		osz = $urandom_range(4, 1);
		if (r == 0) begin
			// long offset table, one-byte offsets keep it cheap
			cnt = 16'h0100 + 16'($urandom_range(2));
			osz = 1;
		end else if (r < 8) begin
			cnt = 16'd0;
			osz = $urandom_range(255);
		end else begin
			cnt = 16'($urandom_range(6, 1));
		end
		push_b(cnt[15:8]);
		push_b(cnt[7:0]);
		push_b(8'(osz));
		if (cnt == 16'd0)
			return;
		for (int k = 0; k < int'(cnt); k++) begin
			val = $urandom;
			for (int j = osz - 1; j >= 0; j--)
				push_b(8'(val >> (8 * j)));
		end
		r = $urandom_range(99);
		if (r < 5)
			dlen = -1;                    // zero final offset
		else if (r < 15)
			dlen = $urandom_range(60, 11);
		else
			dlen = $urandom_range(10);
		fin_off = 32'(dlen + 1);
		for (int j = osz - 1; j >= 0; j--)
			push_b(8'(fin_off >> (8 * j)));
		for (int k = 0; k < dlen; k++)
			push_b(8'($urandom));
	endtask

	task automatic send_index();
		int          mode;
		int          n_go;
		bit          next_dirty;
		logic [15:0] cnt;
		mode       = $urandom_range(99);
		next_dirty = 1'b0;
		seq_q.delete();
		if (mode < 86) begin
			build_index();
			n_go = seq_q.size();
			if (mode >= 72 && n_go > 1) begin
				// truncated stream: next index must restart
				n_go       = $urandom_range(n_go - 1, 1);
				next_dirty = 1'b1;
			end
		end else if (mode < 95) begin
			// header-only cases: empty index or bad offset size
			if ($urandom_range(1)) begin
				cnt = 16'd0;
				push_b(cnt[15:8]);
				push_b(cnt[7:0]);
				push_b(8'($urandom));
			end else begin
				cnt = 16'($urandom_range(65535, 1));
				push_b(cnt[15:8]);
				push_b(cnt[7:0]);
				push_b($urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 5)));
			end
			n_go = seq_q.size();
		end else begin
			// raw noise, random restart marks
			n_go = $urandom_range(8, 1);
			for (int k = 0; k < n_go; k++)
				seq_q.push_back({($urandom_range(7) == 0), 8'($urandom)});
			next_dirty = 1'b1;
		end
		if (mode < 95)
			seq_q[0][8] = dirty ? 1'b1 : 1'($urandom_range(1));
		for (int k = 0; k < n_go; k++)
			send_byte(seq_q[k][7:0], seq_q[k][8], 1'b0, NO_RES);
		dirty = next_dirty;
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : main
		int  target;
		bit  held;
		byte_ch.valid   = 1'b0;
		byte_ch.in_byte = 8'h00;
		byte_ch.restart = 1'b0;
		result_ch.ready = 1'b0;

		// header extremes, widest offset, restart into a bad size,
		// empty index, zero final offset, no data, data bytes
		dir_tab = '{
			'{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h04, 1'b0, 1'b0, NO_RES},
			'{8'hFF, 1'b0, 1'b0, NO_RES},
			'{8'hFF, 1'b0, 1'b0, NO_RES},
			'{8'hFF, 1'b0, 1'b0, NO_RES},
			'{8'hFF, 1'b0, 1'b1, WIDE_OFF},
			'{8'hFF, 1'b1, 1'b0, NO_RES},
			'{8'hFF, 1'b0, 1'b0, NO_RES},
			'{8'hFF, 1'b0, 1'b1, ERR_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'hAB, 1'b0, 1'b1, EMPTY_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h05, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b1, ERR_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h00, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h01, 1'b0, 1'b0, NO_RES},
			'{8'h03, 1'b0, 1'b0, NO_RES},
			'{8'hAA, 1'b0, 1'b0, NO_RES},
			'{8'h55, 1'b0, 1'b0, NO_RES}
		};

		repeat (RST_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_byte(dir_tab[i].val, dir_tab[i].rst, dir_tab[i].pin, dir_tab[i].want);

		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_tab[p];
			stall_pct = stall_tab[p];
			target    = n_sent + PHASE_LEN;
			held      = 1'b0;
			while (n_sent < target) begin
				send_index();
				if (!held && n_sent >= target - PHASE_LEN / 2) begin
					// source holds off until the result queue runs dry
					held = 1'b1;
					byte_ch.valid <= 1'b0;
					wait (pending_results.size() == 0);
					@(negedge clk);
				end
			end
		end

		byte_ch.valid <= 1'b0;
		stall_pct = 0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("tb: %0d byte requests over 4 throttling profiles, %0d cycles",
			n_sent, cycle_cnt);
		$display("tb: results seen: %0d offsets, %0d data, %0d empty, %0d errors",
			n_offs, n_data, n_empty, n_err);
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule : testbench
